// ----- rtl/distinct_subsequence_counter_core_macros.svh -----
// Assertion macros used by the distinct subsequence counter core.
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_CORE_MACROS_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dsc_pkg.sv -----
// Types and constants of the distinct subsequence counter.
package dsc_pkg;

	localparam int CNT_W       = 32;
	localparam int SYM_W       = 8;
	localparam int POS_W       = 4;
	localparam int POS_NUM     = 16;
	localparam int LEN_W       = 5;
	localparam int OP_W        = 2;
	localparam int IN_TDATA_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TEXT  = 2'd2
	} op_t;

	// Broadcast to every cell of the row, already qualified by the handshake.
	typedef struct packed {
		logic             clr;
		logic             txt;
		logic [SYM_W-1:0] sym;
	} cell_ctrl_t;

endpackage

// ----- rtl/distinct_subsequence_counter_core.sv -----
// Top level of the distinct subsequence counter: handshake, cell row and result register.
//
// Usage
//   Input stream s_*: s_tuser holds the op (write pattern symbol, start new
//   text, text symbol); s_tdata holds the symbol and the pattern position.
//   Every request returns one result on m_*: the number of times the first
//   pattern_length pattern symbols occur as a subsequence of the text since
//   the last start request, modulo 2^32. An empty pattern reads as 1.
//   cfg_we/cfg_wdata write pattern_length; write it only while no request is
//   in flight. A length above MAX_PATTERN reads as MAX_PATTERN.
// Timing
//   A row of MAX_PATTERN cells updates every position on the edge that
//   accepts a request; once the result register is free, the selected count
//   loads into it and m_tvalid rises. One request per cycle is sustained
//   while m_tready stays high.
// Reset
//   Counts clear (position zero reads 1), pattern_length is 0. Pattern symbols
//   hold no value until written.
// Stall
//   While a result waits on m_tready and another is pending behind it,
//   s_tready drops and the cells hold.
`include "distinct_subsequence_counter_core_macros.svh"

module distinct_subsequence_counter_core #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dsc_pkg::LEN_W-1:0]      cfg_wdata,   // pattern_length
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dsc_pkg::IN_TDATA_W-1:0] s_tdata,     // symbol[7:0], position[11:8], zero
	input  logic [dsc_pkg::OP_W-1:0]       s_tuser,     // op[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dsc_pkg::CNT_W-1:0]      m_tdata      // count[31:0]
);
	import dsc_pkg::*;

	logic [LEN_W-1:0] pattern_length_q;
	logic             pend_s1;
	logic             m_valid_q;
	logic [CNT_W-1:0] m_data_q;

	logic             out_free;
	logic             capture;
	logic             accept;
	logic             start_acc;
	logic             empty_len;
	op_t              op;
	logic [SYM_W-1:0] in_sym;
	logic [POS_W-1:0] in_pos;
	logic             acc_write;
	cell_ctrl_t       ctrl;
	logic [CNT_W-1:0] sel_count;

	logic [CNT_W-1:0] cnt     [MAX_PATTERN+1];
	logic [CNT_W-1:0] tap_cnt [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] wr_en;
	logic [MAX_PATTERN-1:0] tap;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
		end else if (cfg_we) begin
			pattern_length_q <= cfg_wdata;
		end
	end

	// Handshake: the cells may only advance once the pending result has a slot.
	assign out_free = !m_valid_q || m_tready;
	assign capture  = pend_s1 && out_free;
	assign s_tready = !pend_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign op     = op_t'(s_tuser);
	assign in_sym = s_tdata[SYM_W-1:0];
	assign in_pos = s_tdata[SYM_W +: POS_W];

	assign start_acc = accept && (op == OP_START);
	assign empty_len = (pattern_length_q == '0);

	// Decode the request; the unused op code leaves the cells alone.
	always_comb begin
		acc_write = 1'b0;
		ctrl.clr  = 1'b0;
		ctrl.txt  = 1'b0;
		ctrl.sym  = in_sym;
		case (op)
			OP_WRITE: acc_write = accept;
			OP_START: ctrl.clr  = accept;
			OP_TEXT:  ctrl.txt  = accept;
			default: begin
				acc_write = 1'b0;
			end
		endcase
	end

	// Position zero of the count row is the constant 1.
	assign cnt[0] = CNT_W'(1);

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		// Only positions reachable by the position field can be written.
		if (k < POS_NUM) begin : g_wr
			assign wr_en[k] = acc_write && (in_pos == POS_W'(k));
		end else begin : g_nowr
			assign wr_en[k] = 1'b0;
		end

		// The last cell also serves every length beyond the row.
		if (k + 1 == MAX_PATTERN) begin : g_tap_last
			assign tap[k] = (32'(pattern_length_q) >= 32'(MAX_PATTERN));
		end else begin : g_tap
			assign tap[k] = (32'(pattern_length_q) == 32'(k + 1));
		end

		dsc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.wr         (wr_en[k]),
			.tap        (tap[k]),
			.prev_count (cnt[k]),
			.count      (cnt[k+1]),
			.tap_count  (tap_cnt[k])
		);
	end

	// At most one tap is set, so OR the gated counts together.
	always_comb begin
		sel_count = empty_len ? CNT_W'(1) : '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			sel_count = sel_count | tap_cnt[i];
		end
	end

	// Track the request whose cell update has landed but whose result is not loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (capture) begin
			pend_s1 <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (capture) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			m_data_q <= sel_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Never advance the cells over a result that has nowhere to go.
	`DSC_ASSERT_IMPL(a_hold_on_stall, pend_s1 && !out_free, !s_tready, "request over stall")
	// A start request leaves only the constant position non-zero.
	`DSC_ASSERT_NEXT(a_start_clears, start_acc, sel_count == CNT_W'(empty_len), "start not cleared")
	// A result only appears for a pending request.
	`DSC_ASSERT_IMPL(a_result_source, $rose(m_tvalid), $past(pend_s1), "result without request")

endmodule

// ----- rtl/dsc_cell.sv -----
// One pattern position: stored symbol and running prefix count.
module dsc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsc_pkg::cell_ctrl_t       ctrl,
	input  logic                      wr,
	input  logic                      tap,
	input  logic [dsc_pkg::CNT_W-1:0] prev_count,
	output logic [dsc_pkg::CNT_W-1:0] count,
	output logic [dsc_pkg::CNT_W-1:0] tap_count
);
	import dsc_pkg::*;

	logic [SYM_W-1:0] sym_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			sym_q <= ctrl.sym;
		end
	end

	// Clear on a start request; add the left neighbor's old count on a matching text symbol.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clr) begin
			count_q <= '0;
		end else if (ctrl.txt && (sym_q == ctrl.sym)) begin
			count_q <= count_q + prev_count;
		end
	end

	assign count     = count_q;
	assign tap_count = tap ? count_q : '0;

endmodule

// ----- tb/tb_top.sv -----
// Testbench for distinct_subsequence_counter_core: directed and random request streams checked against a row-count predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dsc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT     = 1000;
	localparam int DRAIN_CYCLES    = 4;
	localparam int RANDOM_REQUESTS = 1950;
	localparam int CALM_FROM       = 700;
	localparam int CALM_TO         = 1000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [LEN_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata   = '0;   // symbol[7:0], position[11:8], zero
	logic [OP_W-1:0]       s_tuser   = '0;   // op[1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [CNT_W-1:0]      m_tdata;          // count[31:0]

	typedef struct {
		logic [CNT_W-1:0] count;
		int unsigned      req;
	} expected_count_t;

	expected_count_t count_q[$];

	// Predictor state: pattern symbols, prefix counts and the active length.
	logic [SYM_W-1:0] pat_sym [POS_NUM];
	logic [CNT_W-1:0] prefix  [POS_NUM+1];
	logic [LEN_W-1:0] pat_len;

	int unsigned req_num    = 0;
	int unsigned mismatches = 0;
	int unsigned quiet      = 0;
	int unsigned rand_sent  = 0;
	bit          no_idle    = 1'b0;

	distinct_subsequence_counter_core #(
		.MAX_PATTERN(POS_NUM)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_prefix();
		foreach (prefix[j]) prefix[j] = '0;
		prefix[0] = 32'd1;
	endfunction

	// Apply one request to the predictor and return the count it reads out.
	function automatic logic [CNT_W-1:0] step_counts(input logic [OP_W-1:0] op,
			input logic [SYM_W-1:0] sym, input logic [POS_W-1:0] pos);
		logic [LEN_W-1:0] eff;
		case (op)
			OP_WRITE: pat_sym[pos] = sym;
			OP_START: clear_prefix();
			OP_TEXT: begin
				// walk down so position j-1 still holds its old count
				for (int j = POS_NUM; j >= 1; j--) begin
					if (pat_sym[j-1] == sym) prefix[j] = prefix[j] + prefix[j-1];
				end
			end
			default: ;
		endcase
		// saturate an oversized length to the full row
		eff = (pat_len > POS_NUM) ? LEN_W'(POS_NUM) : pat_len;
		return prefix[eff];
	endfunction

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want, input int unsigned req);
		$display("count check: %s at request %0d: got %h, expected %h", what, req, got, want);
		mismatches++;
	endtask

	// Send one request; hold it until accepted, then record its expected count.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [POS_W-1:0] pos);
		expected_count_t e;
		if (!no_idle && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 15);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_TDATA_W-SYM_W-POS_W){1'b0}}, pos, sym};
		do @(posedge clk); while (!s_tready);
		e.count = step_counts(op, sym, pos);
		e.req   = req_num;
		req_num++;
		count_q.push_back(e);
	endtask

	// Drop valid and let every outstanding result drain.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (count_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] len);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		pat_len = len;
		cfg_we <= 1'b0;
	endtask

	task automatic random_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [POS_W-1:0] pos);
		send_request(op, sym, pos);
		rand_sent++;
		// a long stretch without idling on either side
		no_idle <= (rand_sent >= CALM_FROM && rand_sent < CALM_TO);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] alph [4],
			input int unsigned mode);
		if (mode == 2) return SYM_W'($urandom_range(0, 255));
		return alph[$urandom_range(0, 3)];
	endfunction

	// Before any pattern is loaded: the empty pattern reads 1.
	task automatic test_reset_values();
		send_request(OP_UNUSED, 8'hFF, 4'hF);
	endtask

	// Load every position, symbols from 00 up to FF.
	task automatic test_pattern_load();
		for (int p = 0; p < POS_NUM; p++) send_request(OP_WRITE, SYM_W'(p * 17), POS_W'(p));
	endtask

	// Pattern "00 11" against text "00 11 00 11": three occurrences.
	task automatic test_text_count();
		write_length(5'd2);
		send_request(OP_START, 8'h00, 4'h0);
		send_request(OP_TEXT, 8'h00, 4'hF);
		send_request(OP_TEXT, 8'h11, 4'h0);
		send_request(OP_TEXT, 8'h00, 4'h0);
		send_request(OP_TEXT, 8'h11, 4'h0);
		send_request(OP_UNUSED, 8'h5A, 4'h3);
	endtask

	// Full length, oversized length, empty pattern, pattern change mid-text.
	task automatic test_length_extremes();
		write_length(5'd16);
		send_request(OP_UNUSED, 8'h00, 4'h0);
		write_length(5'd31);
		send_request(OP_TEXT, 8'hFF, 4'h0);
		write_length(5'd0);
		send_request(OP_TEXT, 8'h00, 4'h0);
		send_request(OP_WRITE, 8'h00, 4'h1);
		write_length(5'd2);
		send_request(OP_TEXT, 8'h00, 4'h0);
	endtask

	// Phases of well-formed texts over small alphabets, with noise mixed in.
	task automatic test_random_texts();
		logic [SYM_W-1:0] alph [4];
		logic [LEN_W-1:0] len;
		int unsigned      mode;
		int unsigned      n;
		int unsigned      r;
		while (rand_sent < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0:       len = 5'd0;
					1:       len = 5'd16;
					default: len = 5'd31;
				endcase
			end else begin
				len = LEN_W'($urandom_range(1, 16));
			end
			// some phases skip the start request, so counts carry across a length change
			write_length(len);
			mode = $urandom_range(0, 3);
			foreach (alph[i]) alph[i] = SYM_W'($urandom_range(0, 255));
			if (mode == 1) begin
				// one symbol only: binomial counts, wraps at full length
				for (int i = 1; i < 4; i++) alph[i] = alph[0];
			end else if (mode == 0) begin
				alph[2] = alph[0];
				alph[3] = alph[1];
			end
			if ($urandom_range(0, 3) != 0) begin
				for (int p = 0; p < POS_NUM; p++)
					random_request(OP_WRITE, pick_symbol(alph, mode), POS_W'(p));
			end else begin
				repeat ($urandom_range(1, 4))
					random_request(OP_WRITE, pick_symbol(alph, mode),
						POS_W'($urandom_range(0, POS_NUM - 1)));
			end
			if ($urandom_range(0, 4) != 0)
				random_request(OP_START, SYM_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, POS_NUM - 1)));
			n = (mode == 1) ? $urandom_range(40, 80) : $urandom_range(10, 80);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					random_request(OP_TEXT, pick_symbol(alph, mode),
						POS_W'($urandom_range(0, POS_NUM - 1)));
				else if (r < 90)
					random_request(OP_TEXT, SYM_W'($urandom_range(0, 255)),
						POS_W'($urandom_range(0, POS_NUM - 1)));
				else if (r < 94)
					random_request(OP_UNUSED, SYM_W'($urandom_range(0, 255)),
						POS_W'($urandom_range(0, POS_NUM - 1)));
				else if (r < 97)
					random_request(OP_WRITE, pick_symbol(alph, mode),
						POS_W'($urandom_range(0, POS_NUM - 1)));
				else
					random_request(OP_START, SYM_W'($urandom_range(0, 255)),
						POS_W'($urandom_range(0, POS_NUM - 1)));
			end
		end
	endtask

	// Receiver: stall now and then, except in the calm stretch.
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 15);
	end

	// Compare each accepted result with the oldest expected count.
	always @(posedge clk) begin : check_result
		expected_count_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (count_q.size() == 0) begin
				report_mismatch("result with no request waiting", m_tdata, '0, req_num);
			end else begin
				e = count_q.pop_front();
				if (m_tdata !== e.count) report_mismatch("count differs", m_tdata, e.count, e.req);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		foreach (pat_sym[p]) pat_sym[p] = '0;
		clear_prefix();
		pat_len = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_pattern_load();
		test_text_count();
		test_length_extremes();
		test_random_texts();

		wait_idle();
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
